@@ rtl/qrs_pkg.sv @@
// qrs_pkg: shared widths, codes and word types of the quadratic root solver
// used by qrs_sqrt_cell, qrs_div_cell and quadratic_root_solver; no dependencies
package qrs_pkg;

  localparam int COEF_W = 32;
  localparam int DISC_W = 66;   // exact discriminant magnitude, raw integer
  localparam int ROOT_W = 33;   // floor sqrt of the discriminant
  localparam int REM_W  = 35;   // sqrt partial remainder
  localparam int DEN_W  = 33;   // divisor magnitude, at most 2^32

  localparam logic [COEF_W-1:0] TOL_RESET = 32'd4295;
  localparam logic [COEF_W-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [COEF_W-1:0] Q_MIN     = 32'h8000_0000;

  // root class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;
  localparam logic [1:0] CLS_TWO  = 2'd2;
  localparam logic [1:0] CLS_INF  = 2'd3;

  // which numerators and divisor the root path uses
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LIN,
    MODE_DBL,
    MODE_TWO
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [1:0]               cls;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_ctx_t;

  // word moved along the square root chain
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DISC_W-1:0] dsh;
    coef_ctx_t         ctx;
  } sq_word_t;

  // side data moved along the divider chain
  typedef struct packed {
    logic [1:0]       cls;
    logic             neg1;
    logic             neg2;
    logic [DEN_W-1:0] den;
  } dv_ctx_t;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
// qrs_sqrt_cell: one root bit of a restoring digit-by-digit square root
// depends on qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  sq_word_t in_word,
  output logic     out_valid_r,
  output sq_word_t out_word_r
);

  logic [REM_W+1:0] part;
  logic [REM_W+1:0] trial;
  logic             fits;
  sq_word_t         word_nxt;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    part     = {in_word.rem, in_word.dsh[DISC_W-1 -: 2]};
    trial    = (REM_W+2)'({in_word.root, 2'b01});
    fits     = part >= trial;
    word_nxt = in_word;
    word_nxt.rem  = fits ? REM_W'(part - trial) : REM_W'(part);
    word_nxt.root = {in_word.root[ROOT_W-2:0], fits};
    word_nxt.dsh  = in_word.dsh << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= word_nxt;
    end
  end

endmodule

@@ rtl/qrs_div_cell.sv @@
// qrs_div_cell: one quotient bit of two restoring dividers sharing a divisor
// depends on qrs_pkg
module qrs_div_cell import qrs_pkg::*; #(
  parameter int NumW = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  dv_ctx_t          in_ctx,
  input  logic [DEN_W-1:0] in_rem1,
  input  logic [DEN_W-1:0] in_rem2,
  input  logic [NumW-1:0]  in_acc1,
  input  logic [NumW-1:0]  in_acc2,
  output logic             out_valid_r,
  output dv_ctx_t          out_ctx_r,
  output logic [DEN_W-1:0] out_rem1_r,
  output logic [DEN_W-1:0] out_rem2_r,
  output logic [NumW-1:0]  out_acc1_r,
  output logic [NumW-1:0]  out_acc2_r
);

  // shift in one dividend bit, subtract if it fits, shift the quotient bit in
  function automatic logic [DEN_W+NumW-1:0] div_step(
    input logic [DEN_W-1:0] rem,
    input logic [NumW-1:0]  acc,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0] part;
    logic           fits;
    part = {rem, acc[NumW-1]};
    fits = part >= {1'b0, den};
    div_step = {fits ? DEN_W'(part - {1'b0, den}) : DEN_W'(part), acc[NumW-2:0], fits};
  endfunction

  logic [DEN_W+NumW-1:0] lane1_nxt;
  logic [DEN_W+NumW-1:0] lane2_nxt;

  assign lane1_nxt = div_step(in_rem1, in_acc1, in_ctx.den);
  assign lane2_nxt = div_step(in_rem2, in_acc2, in_ctx.den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx_r  <= in_ctx;
      out_rem1_r <= lane1_nxt[DEN_W+NumW-1:NumW];
      out_acc1_r <= lane1_nxt[NumW-1:0];
      out_rem2_r <= lane2_nxt[DEN_W+NumW-1:NumW];
      out_acc2_r <= lane2_nxt[NumW-1:0];
    end
  end

endmodule

@@ rtl/quadratic_root_solver.sv @@
// quadratic_root_solver: roots of a*x^2+b*x+c=0 in signed fixed point
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
//
//   port group  dir  handshake          word
//   in_*        in   in_valid/in_ready  coef_quadratic, coef_linear, coef_constant
//   out_*       out  out_valid/out_ready root_class, root_first, root_second, saturated
//   cfg_*       in   cfg_wr_en          zero_tolerance
//
// one word per cycle enters while the pipeline is not held
// the pipeline is the 33-cell square root chain and the (35 + FRACTION_BITS)-cell
// divider chain, plus four front stages, three numerator stages and the output register
// the whole pipeline moves together; it holds while out_valid is high and out_ready low
// rst_n is synchronous: it empties the pipeline and loads zero_tolerance with 4295
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COEF_W-1:0] in_coef_quadratic,
  input  logic signed [COEF_W-1:0] in_coef_linear,
  input  logic signed [COEF_W-1:0] in_coef_constant,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_root_class,
  output logic signed [COEF_W-1:0] out_root_first,
  output logic signed [COEF_W-1:0] out_root_second,
  output logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  logic [COEF_W-1:0]        cfg_wr_data
);

  localparam int NUM_W    = 35 + FRACTION_BITS;
  localparam int SQ_CELLS = DISC_W / 2;

  function automatic logic [COEF_W-1:0] mag32(input logic signed [COEF_W-1:0] v);
    mag32 = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
  endfunction

  function automatic logic coef_zero(input logic [COEF_W-1:0] mag,
                                     input logic [COEF_W-1:0] tol);
    coef_zero = {mag, 32'd0} <= ({32'd0, tol} << FRACTION_BITS);
  endfunction

  // saturate a quotient magnitude and apply the sign; msb is the clamp flag
  function automatic logic [COEF_W:0] clamp_root(input logic [NUM_W-1:0] q,
                                                 input logic neg);
    logic big;
    if (neg) begin
      big = (q[NUM_W-1:32] != '0) || (q[31] && (q[30:0] != '0));
      clamp_root = {big, big ? Q_MIN : COEF_W'(-q[31:0])};
    end else begin
      big = q[NUM_W-1:31] != '0;
      clamp_root = {big, big ? Q_MAX : q[31:0]};
    end
  endfunction

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // tolerance register
  logic [COEF_W-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // stage 1: input register
  logic                     v1_r;
  logic signed [COEF_W-1:0] a1_r, b1_r, c1_r;

  // stage 2: products and coefficient zero tests
  logic                     v2_r;
  logic [63:0]              bsq_r, ac_r;
  logic                     za2_r, zb2_r, zc2_r, acneg2_r;
  logic signed [COEF_W-1:0] a2_r, b2_r, c2_r;

  // stage 3: discriminant magnitude and sign
  logic                     v3_r;
  logic [DISC_W-1:0]        dmag3_r;
  logic                     dneg3_r, za3_r, zb3_r, zc3_r;
  logic signed [COEF_W-1:0] a3_r, b3_r, c3_r;

  // stage 4: classification, head of the sqrt chain
  logic                     v4_r;
  sq_word_t                 sq_in_r;

  logic [DISC_W-1:0] ac4, bsq_w, dsum, ddiff, dndiff;
  logic              ac_le;
  logic              zd;
  coef_ctx_t         ctx_nxt;

  always_comb begin
    ac4    = {ac_r, 2'b00};
    bsq_w  = DISC_W'(bsq_r);
    dsum   = bsq_w + ac4;
    ddiff  = bsq_w - ac4;
    dndiff = ac4 - bsq_w;
    ac_le  = ac4 <= bsq_w;
  end

  always_comb begin
    zd = {dmag3_r, 32'd0} <= ((DISC_W+32)'(tol_r) << (2 * FRACTION_BITS));
    ctx_nxt.a = a3_r;
    ctx_nxt.b = b3_r;
    ctx_nxt.c = c3_r;
    if (za3_r) begin
      if (zb3_r) begin
        ctx_nxt.mode = MODE_NONE;
        ctx_nxt.cls  = zc3_r ? CLS_INF : CLS_NONE;
      end else begin
        ctx_nxt.mode = MODE_LIN;
        ctx_nxt.cls  = CLS_ONE;
      end
    end else if (zd) begin
      ctx_nxt.mode = MODE_DBL;
      ctx_nxt.cls  = CLS_ONE;
    end else if (!dneg3_r) begin
      ctx_nxt.mode = MODE_TWO;
      ctx_nxt.cls  = CLS_TWO;
    end else begin
      ctx_nxt.mode = MODE_NONE;
      ctx_nxt.cls  = CLS_NONE;
    end
  end

  // front stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_coef_quadratic;
      b1_r <= in_coef_linear;
      c1_r <= in_coef_constant;

      bsq_r    <= mag32(b1_r) * mag32(b1_r);
      ac_r     <= mag32(a1_r) * mag32(c1_r);
      za2_r    <= coef_zero(mag32(a1_r), tol_r);
      zb2_r    <= coef_zero(mag32(b1_r), tol_r);
      zc2_r    <= coef_zero(mag32(c1_r), tol_r);
      acneg2_r <= (a1_r[COEF_W-1] != c1_r[COEF_W-1]) && (c1_r != '0);
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      c2_r     <= c1_r;

      if (acneg2_r) begin
        dmag3_r <= dsum;
        dneg3_r <= 1'b0;
      end else if (ac_le) begin
        dmag3_r <= ddiff;
        dneg3_r <= 1'b0;
      end else begin
        dmag3_r <= dndiff;
        dneg3_r <= 1'b1;
      end
      za3_r <= za2_r;
      zb3_r <= zb2_r;
      zc3_r <= zc2_r;
      a3_r  <= a2_r;
      b3_r  <= b2_r;
      c3_r  <= c2_r;

      sq_in_r.rem  <= '0;
      sq_in_r.root <= '0;
      sq_in_r.dsh  <= dmag3_r;
      sq_in_r.ctx  <= ctx_nxt;
    end
  end

  // square root chain
  logic     sq_v [0:SQ_CELLS];
  sq_word_t sq_w [0:SQ_CELLS];

  assign sq_v[0] = v4_r;
  assign sq_w[0] = sq_in_r;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (sq_v[i]),
      .in_word    (sq_w[i]),
      .out_valid_r(sq_v[i+1]),
      .out_word_r (sq_w[i+1])
    );
  end

  // numerator stages: signed numerators, magnitudes, rounded dividends
  logic               v5_r, v6_r, v7_r;
  logic signed [34:0] n1_r, n2_r;
  logic signed [33:0] den5_r;
  logic [1:0]         cls5_r, cls6_r;
  logic [33:0]        nm1_r, nm2_r;
  logic [DEN_W-1:0]   dm_r;
  logic               neg1_r, neg2_r;
  dv_ctx_t            dv_in_r;
  logic [NUM_W-1:0]   acc1_in_r, acc2_in_r;

  coef_ctx_t          sq_ctx;
  logic signed [34:0] nb, sroot, n1_nxt, n2_nxt;
  logic signed [33:0] den_nxt;

  always_comb begin
    sq_ctx = sq_w[SQ_CELLS].ctx;
    nb     = -35'(sq_ctx.b);
    sroot  = $signed({2'b00, sq_w[SQ_CELLS].root});
    unique case (sq_ctx.mode)
      MODE_LIN: begin
        n1_nxt  = -35'(sq_ctx.c);
        n2_nxt  = -35'(sq_ctx.c);
        den_nxt = 34'(sq_ctx.b);
      end
      MODE_TWO: begin
        n1_nxt  = nb + sroot;
        n2_nxt  = nb - sroot;
        den_nxt = 34'(sq_ctx.a) <<< 1;
      end
      default: begin
        n1_nxt  = nb;
        n2_nxt  = nb;
        den_nxt = 34'(sq_ctx.a) <<< 1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= sq_v[SQ_CELLS];
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n1_nxt;
      n2_r   <= n2_nxt;
      den5_r <= den_nxt;
      cls5_r <= sq_ctx.cls;

      nm1_r  <= n1_r[34] ? 34'(-n1_r) : 34'(n1_r);
      nm2_r  <= n2_r[34] ? 34'(-n2_r) : 34'(n2_r);
      dm_r   <= den5_r[33] ? DEN_W'(-den5_r) : DEN_W'(den5_r);
      neg1_r <= n1_r[34] != den5_r[33];
      neg2_r <= n2_r[34] != den5_r[33];
      cls6_r <= cls5_r;

      acc1_in_r    <= (NUM_W'(nm1_r) << FRACTION_BITS) + NUM_W'(dm_r >> 1);
      acc2_in_r    <= (NUM_W'(nm2_r) << FRACTION_BITS) + NUM_W'(dm_r >> 1);
      dv_in_r.cls  <= cls6_r;
      dv_in_r.neg1 <= neg1_r;
      dv_in_r.neg2 <= neg2_r;
      dv_in_r.den  <= dm_r;
    end
  end

  // divider chain
  logic             dv_v    [0:NUM_W];
  dv_ctx_t          dv_c    [0:NUM_W];
  logic [DEN_W-1:0] dv_rem1 [0:NUM_W];
  logic [DEN_W-1:0] dv_rem2 [0:NUM_W];
  logic [NUM_W-1:0] dv_acc1 [0:NUM_W];
  logic [NUM_W-1:0] dv_acc2 [0:NUM_W];

  assign dv_v[0]    = v7_r;
  assign dv_c[0]    = dv_in_r;
  assign dv_rem1[0] = '0;
  assign dv_rem2[0] = '0;
  assign dv_acc1[0] = acc1_in_r;
  assign dv_acc2[0] = acc2_in_r;

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    qrs_div_cell #(
      .NumW(NUM_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (dv_v[j]),
      .in_ctx     (dv_c[j]),
      .in_rem1    (dv_rem1[j]),
      .in_rem2    (dv_rem2[j]),
      .in_acc1    (dv_acc1[j]),
      .in_acc2    (dv_acc2[j]),
      .out_valid_r(dv_v[j+1]),
      .out_ctx_r  (dv_c[j+1]),
      .out_rem1_r (dv_rem1[j+1]),
      .out_rem2_r (dv_rem2[j+1]),
      .out_acc1_r (dv_acc1[j+1]),
      .out_acc2_r (dv_acc2[j+1])
    );
  end

  // output register: saturate, sign, and zero the rootless classes
  logic [COEF_W:0] r1_nxt, r2_nxt;
  logic            has_root;
  logic [1:0]      root_class_r;
  logic [COEF_W-1:0] root_first_r, root_second_r;
  logic            saturated_r;

  assign r1_nxt   = clamp_root(dv_acc1[NUM_W], dv_c[NUM_W].neg1);
  assign r2_nxt   = clamp_root(dv_acc2[NUM_W], dv_c[NUM_W].neg2);
  assign has_root = (dv_c[NUM_W].cls == CLS_ONE) || (dv_c[NUM_W].cls == CLS_TWO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_class_r  <= dv_c[NUM_W].cls;
      root_first_r  <= has_root ? r1_nxt[COEF_W-1:0] : '0;
      root_second_r <= has_root ? r2_nxt[COEF_W-1:0] : '0;
      saturated_r   <= has_root && (r1_nxt[COEF_W] || r2_nxt[COEF_W]);
    end
  end

  assign out_root_class  = root_class_r;
  assign out_root_first  = $signed(root_first_r);
  assign out_root_second = $signed(root_second_r);
  assign out_saturated   = saturated_r;

  // checks on the result word
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_rootless_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_root_class == CLS_NONE) || (out_root_class == CLS_INF)) |->
      (out_root_first == '0) && (out_root_second == '0) && !out_saturated)
    else $error("rootless word carries roots or clamp flag");

  a_single_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_class == CLS_ONE) |-> out_root_first == out_root_second)
    else $error("single root word has two different roots");

  a_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_root_class) && $stable(out_root_first) &&
      $stable(out_root_second) && $stable(out_saturated))
    else $error("result word changed while stalled");

endmodule

@@ dv/quadratic_root_solver_tb.sv @@
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// depends on qrs_pkg and quadratic_root_solver; a local solver predicts every word
// directed corner cases, tolerance sweeps and random coefficient sets with and without random stalls
module quadratic_root_solver_tb import qrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 16;
  localparam int MAX_GAP    = 13;
  localparam int DRAIN_WAIT = 120;
  localparam int STALL_LIM  = 4000;

  typedef struct {
    logic [1:0]        cls;
    logic [COEF_W-1:0] r1;
    logic [COEF_W-1:0] r2;
    logic              sat;
  } root_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [COEF_W-1:0] in_coef_quadratic;
  logic signed [COEF_W-1:0] in_coef_linear;
  logic signed [COEF_W-1:0] in_coef_constant;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_root_class;
  logic signed [COEF_W-1:0] out_root_first;
  logic signed [COEF_W-1:0] out_root_second;
  logic                     out_saturated;
  logic                     cfg_wr_en;
  logic [COEF_W-1:0]        cfg_wr_data;

  root_word_t  roots_pending[$];
  logic [31:0] tol_shadow;
  bit          gaps_on;
  int          err_count;
  int          sent_count;
  int          got_count;
  int          out_stall;
  int          idle_cycles;

  quadratic_root_solver #(.FRACTION_BITS(FRAC)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_coef_quadratic (in_coef_quadratic),
    .in_coef_linear    (in_coef_linear),
    .in_coef_constant  (in_coef_constant),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_root_class    (out_root_class),
    .out_root_first    (out_root_first),
    .out_root_second   (out_root_second),
    .out_saturated     (out_saturated),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // magnitude with 'scale' fraction bits against the tolerance
  function automatic bit is_tiny(logic [127:0] mag, int scale);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = mag << 32;
    rhs = {96'd0, tol_shadow} << scale;
    return lhs <= rhs;
  endfunction

  // num * 2^f / den, rounded half away from zero, clamped to 32 bits
  function automatic logic [31:0] fx_quotient(longint num, longint den, ref logic sat);
    longint unsigned nm;
    longint unsigned dm;
    longint unsigned q;
    bit neg;
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    if (dm == 0) return 32'd0;
    nm = nm << FRAC;
    q  = (nm + dm / 2) / dm;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        q   = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) begin
      q   = 64'h7fff_ffff;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(logic [127:0] d);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int k = 33; k >= 0; k--) begin
      cand = res | (128'd1 << k);
      if (cand * cand <= d) res = cand;
    end
    return res[63:0];
  endfunction

  // expected word for one coefficient set
  function automatic root_word_t solve_roots(logic [31:0] ra, logic [31:0] rb,
                                             logic [31:0] rc);
    root_word_t   w;
    longint       a;
    longint       b;
    longint       c;
    longint       s;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mc;
    logic [127:0] b2;
    logic [127:0] ac4;
    logic [127:0] dmag;
    bit           dneg;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    c = longint'($signed(rc));
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    w.cls = CLS_NONE;
    w.r1 = '0;
    w.r2 = '0;
    w.sat = 1'b0;
    dneg = 1'b0;
    if (is_tiny(ma, FRAC)) begin
      if (is_tiny(mb, FRAC)) begin
        w.cls = is_tiny(mc, FRAC) ? CLS_INF : CLS_NONE;
      end else begin
        w.cls = CLS_ONE;
        w.r1 = fx_quotient(-c, b, w.sat);
        w.r2 = w.r1;
      end
    end else begin
      b2  = mb * mb;
      ac4 = (ma * mc) << 2;
      if (((a < 0) != (c < 0)) && c != 0) dmag = b2 + ac4;
      else if (ac4 <= b2) dmag = b2 - ac4;
      else begin
        dmag = ac4 - b2;
        dneg = 1'b1;
      end
      if (is_tiny(dmag, 2 * FRAC)) begin
        w.cls = CLS_ONE;
        w.r1 = fx_quotient(-b, 2 * a, w.sat);
        w.r2 = w.r1;
      end else if (!dneg) begin
        s = longint'(floor_sqrt(dmag));
        w.cls = CLS_TWO;
        w.r1 = fx_quotient(-b + s, 2 * a, w.sat);
        w.r2 = fx_quotient(-b - s, 2 * a, w.sat);
      end
    end
    return w;
  endfunction

  // send one coefficient word, entered and left at a falling edge
  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_coef_quadratic = a;
    in_coef_linear    = b;
    in_coef_constant  = c;
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    roots_pending.push_back(solve_roots(a, b, c));
    sent_count++;
    @(negedge clk);
  endtask

  // write the tolerance once the pipeline is empty
  task automatic set_tolerance(logic [31:0] v);
    in_valid = 1'b0;
    wait (roots_pending.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    tol_shadow = v;
  endtask

  // coefficients built from chosen roots so both classes with roots show up
  task automatic send_built(bit dbl);
    longint k;
    longint r1;
    longint r2;
    k  = $urandom_range(1 << 6, 1 << 20);
    r1 = longint'($signed($urandom_range(0, 1 << 23))) - (1 << 22);
    r2 = dbl ? r1 : longint'($signed($urandom_range(0, 1 << 23))) - (1 << 22);
    if ($urandom_range(0, 1)) k = -k;
    send_coefs(32'(k), 32'(-((k * (r1 + r2)) >>> FRAC)), 32'(((k * r1 >>> FRAC) * r2) >>> FRAC));
  endtask

  task automatic send_noise();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    case ($urandom_range(0, 4))
      0: a = 32'($signed($urandom_range(0, 4)) - 2);
      1: begin
        a = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        b = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      end
      2: c = 32'($signed($urandom_range(0, 1 << 10)) - (1 << 9));
      default: ;
    endcase
    send_coefs(a, b, c);
  endtask

  // corner coefficients: extremes, linear, none, infinite, double, saturation
  task automatic test_corners();
    send_coefs(32'd0, 32'd0, 32'd0);
    send_coefs(32'd0, 32'd0, 32'h0001_0000);
    send_coefs(32'd0, 32'h0002_0000, 32'hfffc_0000);
    send_coefs(32'd0, 32'd1, 32'h7fff_ffff);
    send_coefs(32'd0, 32'd1, 32'h8000_0000);
    send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
    send_coefs(32'h0001_0000, 32'd0, 32'hffff_0000);
    send_coefs(32'h0001_0000, 32'd0, 32'h0001_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_coefs(32'd1, 32'h8000_0000, 32'd0);
    send_coefs(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'd1, 32'd0, 32'h8000_0000);
    send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
    send_coefs(32'hffff_0000, 32'h0003_0000, 32'h8000_0000);
  endtask

  // tolerance at zero, at full scale and a middle value
  task automatic test_tolerance_sweep();
    logic [31:0] vals[3];
    vals = '{32'd0, 32'hffff_ffff, 32'd65536};
    foreach (vals[i]) begin
      set_tolerance(vals[i]);
      send_coefs(32'd0, 32'd0, 32'd0);
      send_coefs(32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff);
      send_coefs(32'h0001_0000, 32'h0000_ffff, 32'd1);
      send_coefs(32'hffff_0001, 32'h0001_0000, 32'h0000_8000);
      repeat (30) send_noise();
    end
  endtask

  // mostly well-formed coefficient sets with random roots, some noise
  task automatic test_random(int count, logic [31:0] tol, bit gaps);
    set_tolerance(tol);
    gaps_on = gaps;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_built(1'b0);
        4, 5:       send_built(1'b1);
        default:    send_noise();
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // result checker and output stall generator
  always @(posedge clk) begin
    root_word_t w;
    if (rst_n && out_valid && out_ready) begin
      got_count++;
      out_stall <= gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (roots_pending.size() == 0) begin
        $error("unexpected result word");
        err_count++;
      end else begin
        w = roots_pending.pop_front();
        if (out_root_class !== w.cls) begin
          $error("root_class: expected %0d, got %0d", w.cls, out_root_class);
          err_count++;
        end
        if (out_root_first !== w.r1) begin
          $error("root_first: expected %h, got %h", w.r1, out_root_first);
          err_count++;
        end
        if (out_root_second !== w.r2) begin
          $error("root_second: expected %h, got %h", w.r2, out_root_second);
          err_count++;
        end
        if (out_saturated !== w.sat) begin
          $error("saturated: expected %0d, got %0d", w.sat, out_saturated);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // watchdog on cycles without any accepted word or tolerance write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIM) begin
      $display("quadratic_root_solver_tb: done, errors");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coef_quadratic = '0;
    in_coef_linear = '0;
    in_coef_constant = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tol_shadow = TOL_RESET;
    gaps_on = 1'b1;
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    out_stall = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_corners();
    test_tolerance_sweep();
    test_random(500, TOL_RESET, 1'b1);
    test_random(300, 32'd0, 1'b0);
    test_random(300, 32'h0100_0000, 1'b1);
    test_random(230, 32'd4295, 1'b0);
    in_valid = 1'b0;
    wait (roots_pending.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d coefficient words, checked %0d result words, %0d mismatches",
             sent_count, got_count, err_count);
    $display("covered corners, tolerance at zero and full scale, random roots under stalls");
    if (err_count == 0) begin
      $display("quadratic_root_solver_tb: done, clean");
    end else begin
      $display("quadratic_root_solver_tb: done, errors");
    end
    $finish;
  end

endmodule
